// ===== hw/rtl/mm_pkg.sv =====
package mm_pkg;

    localparam int MAX_DIM       = 8;
    localparam int ELEMENT_WIDTH = 16;
    localparam int IDX_W         = $clog2(MAX_DIM);
    localparam int ADDR_W        = 2 * IDX_W;
    localparam int DIM_REG_W     = 4;
    localparam int PROD_W        = 2 * ELEMENT_WIDTH;
    localparam int SUM_W         = 35;
    localparam int CFG_IDX_W     = 2;
    localparam int ACTION_W      = 2;
    localparam int IN_FIELDS_W   = 2 * IDX_W + ELEMENT_WIDTH;
    localparam int IN_DATA_W     = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W  = 2 * IDX_W + SUM_W;
    localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [DIM_REG_W-1:0] dim_reg_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD_LEFT  = 2'd0,
        ACT_LOAD_RIGHT = 2'd1,
        ACT_START      = 2'd2
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_ROWS  = 2'd0,
        CFG_INNER_SIZE = 2'd1,
        CFG_RIGHT_COLS = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN
    } mm_state_t;

    // controller to datapath
    typedef struct packed {
        logic  wr_left;
        logic  wr_right;
        logic  issue;
        logic  first;
        addr_t left_addr;
        addr_t right_addr;
        logic  emit;
        idx_t  emit_row;
        idx_t  emit_col;
        logic  emit_last;
    } mm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } mm_status_t;

    // last index of a dimension, zero read as one, large values clipped
    function automatic idx_t dim_last(input dim_reg_t v);
        idx_t res;
        if (v == '0)
            res = '0;
        else if (int'(v) > MAX_DIM)
            res = IDX_W'(MAX_DIM - 1);
        else
            res = IDX_W'(v - 1'b1);
        return res;
    endfunction

endpackage

// ===== hw/rtl/mm_ctrl.sv =====
module mm_ctrl
    import mm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  dim_reg_t             cfg_data,
    input  logic                 in_valid,
    input  logic [ACTION_W-1:0]  in_action,
    output logic                 in_ready,
    output mm_cmd_t              cmd,
    input  mm_status_t           st
);

    mm_state_t state_reg, state_next;
    dim_reg_t  rows_cfg_reg, inner_cfg_reg, cols_cfg_reg;
    idx_t      r_reg, r_next;
    idx_t      c_reg, c_next;
    idx_t      k_reg, k_next;
    idx_t      r_last, c_last, k_last;
    logic      in_xfer;
    logic      is_last;

    assign r_last = dim_last(rows_cfg_reg);
    assign k_last = dim_last(inner_cfg_reg);
    assign c_last = dim_last(cols_cfg_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg  <= DIM_REG_W'(MAX_DIM);
            inner_cfg_reg <= DIM_REG_W'(MAX_DIM);
            cols_cfg_reg  <= DIM_REG_W'(MAX_DIM);
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_LEFT_ROWS:  rows_cfg_reg  <= cfg_data;
                CFG_INNER_SIZE: inner_cfg_reg <= cfg_data;
                CFG_RIGHT_COLS: cols_cfg_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            r_reg     <= '0;
            c_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            k_reg     <= k_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign is_last  = (r_reg == r_last) && (c_reg == c_last);

    always_comb
    begin
        state_next     = state_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        k_next         = k_reg;
        cmd            = '0;
        cmd.left_addr  = {r_reg, k_reg};
        cmd.right_addr = {k_reg, c_reg};
        cmd.first      = (k_reg == '0);
        cmd.emit_row   = r_reg;
        cmd.emit_col   = c_reg;
        cmd.emit_last  = is_last;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    case (action_t'(in_action))
                        ACT_LOAD_LEFT:  cmd.wr_left  = 1'b1;
                        ACT_LOAD_RIGHT: cmd.wr_right = 1'b1;
                        ACT_START:
                        begin
                            r_next     = '0;
                            c_next     = '0;
                            k_next     = '0;
                            state_next = ST_MAC;
                        end
                        default:        ;
                    endcase
                end
            end
            ST_MAC:
            begin
                cmd.issue = 1'b1;
                if (k_reg == k_last)
                begin
                    k_next     = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // wait for the last product to land in the accumulator and for the output register to be free
                if (!st.pipe_busy && st.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (is_last)
                    begin
                        r_next     = '0;
                        c_next     = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        if (c_reg == c_last)
                        begin
                            c_next = '0;
                            r_next = r_reg + 1'b1;
                        end
                        else
                        begin
                            c_next = c_reg + 1'b1;
                        end
                        state_next = ST_MAC;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/mm_datapath.sv =====
module mm_datapath
    import mm_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  mm_cmd_t                         cmd,
    output mm_status_t                      st,
    input  idx_t                            wr_row,
    input  idx_t                            wr_col,
    input  logic signed [ELEMENT_WIDTH-1:0] wr_element,
    output logic                            out_valid,
    input  logic                            out_ready,
    output idx_t                            out_row,
    output idx_t                            out_col,
    output logic signed [SUM_W-1:0]         out_sum,
    output logic                            out_last
);

    logic signed [ELEMENT_WIDTH-1:0] left_mem  [MAX_DIM*MAX_DIM];
    logic signed [ELEMENT_WIDTH-1:0] right_mem [MAX_DIM*MAX_DIM];

    logic signed [ELEMENT_WIDTH-1:0] left_data_reg, right_data_reg;
    logic signed [PROD_W-1:0]        prod_reg;
    logic signed [PROD_W-1:0]        prod_next;
    logic signed [SUM_W-1:0]         acc_reg;
    logic signed [SUM_W-1:0]         prod_ext;
    logic                            v1_reg, first1_reg;
    logic                            v2_reg, first2_reg;
    logic                            out_valid_reg;
    idx_t                            out_row_reg, out_col_reg;
    logic signed [SUM_W-1:0]         out_sum_reg;
    logic                            out_last_reg;
    addr_t                           wr_addr;

    assign wr_addr = {wr_row, wr_col};

    always_ff @(posedge clk)
    begin
        if (cmd.wr_left)
            left_mem[wr_addr] <= wr_element;
        left_data_reg <= left_mem[cmd.left_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_right)
            right_mem[wr_addr] <= wr_element;
        right_data_reg <= right_mem[cmd.right_addr];
    end

    assign prod_next = left_data_reg * right_data_reg;
    assign prod_ext  = {{(SUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            first1_reg <= 1'b0;
            v2_reg     <= 1'b0;
            first2_reg <= 1'b0;
        end
        else
        begin
            v1_reg     <= cmd.issue;
            first1_reg <= cmd.first;
            v2_reg     <= v1_reg;
            first2_reg <= first1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (v2_reg)
            acc_reg <= first2_reg ? prod_ext : acc_reg + prod_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_row_reg  <= cmd.emit_row;
            out_col_reg  <= cmd.emit_col;
            out_sum_reg  <= acc_reg;
            out_last_reg <= cmd.emit_last;
        end
    end

    assign st.pipe_busy = v1_reg || v2_reg;
    assign st.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_sum   = out_sum_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== hw/rtl/matrix_multiply.sv =====
// channel  | direction | handshake            | payload
// s_*      | in        | s_tvalid / s_tready  | s_tdata: row, col, element; s_tuser: action
// m_*      | out       | m_tvalid / m_tready  | m_tdata: row, col, dot_sum; m_tlast: last
// cfg_*    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// a start blocks the input until the last result is in the output register
// each result element issues one multiply-accumulate per cycle over the inner dimension,
// then waits for the memory read and multiplier stages to drain into the accumulator
// the output register frees the next result to be computed while one waits on m_tready
// async active-low reset; element stores are not cleared, so no startup pass is needed
module matrix_multiply
    import mm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // row_index[2:0], col_index[5:3], element[21:6]
    input  logic [ACTION_W-1:0]   s_tuser,   // action[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // out_row[2:0], out_col[5:3], dot_sum[40:6]
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  dim_reg_t              cfg_data
);

    mm_cmd_t                         cmd;
    mm_status_t                      st;
    idx_t                            in_row, in_col;
    logic signed [ELEMENT_WIDTH-1:0] in_element;
    idx_t                            res_row, res_col;
    logic signed [SUM_W-1:0]         res_sum;

    assign in_row     = s_tdata[IDX_W-1:0];
    assign in_col     = s_tdata[2*IDX_W-1:IDX_W];
    assign in_element = s_tdata[IN_FIELDS_W-1:2*IDX_W];

    assign cfg_ready = 1'b1;

    mm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_action (s_tuser),
        .in_ready  (s_tready),
        .cmd       (cmd),
        .st        (st)
    );

    mm_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .wr_row     (in_row),
        .wr_col     (in_col),
        .wr_element (in_element),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_row    (res_row),
        .out_col    (res_col),
        .out_sum    (res_sum),
        .out_last   (m_tlast)
    );

    assign m_tdata = {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}}, res_sum, res_col, res_row};

    // no input transfer while products are still in flight
    a_no_input_while_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> !st.pipe_busy
    ) else $error("input transfer with multiply pipeline busy");

    // a result is only loaded into a free output register
    a_emit_into_free: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!m_tvalid || m_tready)
    ) else $error("result overwrote a pending output transfer");

    // a start transfer closes the input for at least the next cycle
    a_start_blocks_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == ACT_START)) |=> !s_tready
    ) else $error("input reopened right after start");

    // memory writes never overlap a multiply pass
    a_no_write_during_mac: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd.wr_left || cmd.wr_right) |-> !cmd.issue && !st.pipe_busy
    ) else $error("store written during a multiply pass");

endmodule
